// ===== rtl/rrtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared constants and types of the round robin task table.
// ----------------------------------------------------------------------------
package rrtt_pkg;

	localparam int NUM_SLOTS_DEF     = 4;
	localparam int STACK_BYTES_DEF   = 2000;
	localparam int ENTRY_FRAME_BYTES = 21 * 8;

	localparam int SP_W     = 64;
	localparam int SS_W     = 16;
	localparam int SCREEN_W = 8;
	localparam int ID_W     = 8;
	localparam int BASE_W   = 48;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = BASE_W;

	localparam logic [CFG_INDEX_W-1:0] REG_MULTITASK_ENABLE  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STACK_REGION_BASE = 1'd1;

	localparam logic [MODE_W-1:0] MODE_SWITCH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_TASK = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
		logic rd;
	} rrtt_cmd_t;

endpackage

// ===== rtl/rrtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrtt_ctrl
// Sequencer: capture a word, update the table, read the current slot, report.
// ----------------------------------------------------------------------------
module rrtt_ctrl
	import rrtt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output rrtt_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_READ;
			ST_READ: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_DONE);
	assign cmd.load = start && (state_q == ST_IDLE);
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.rd   = (state_q == ST_READ);

endmodule

// ===== rtl/rrtt_dp.sv =====
// ----------------------------------------------------------------------------
// rrtt_dp
// Slot table, scheduler state, configuration registers and result registers.
// ----------------------------------------------------------------------------
module rrtt_dp
	import rrtt_pkg::*;
#(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int STACK_BYTES = STACK_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rrtt_cmd_t              cmd,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [MODE_W-1:0]      mode,
	input  logic [SP_W-1:0]        saved_sp,
	input  logic [SS_W-1:0]        saved_ss,
	input  logic [SCREEN_W-1:0]    screen,
	output logic [STATUS_W-1:0]    status,
	output logic [ID_W-1:0]        new_id,
	output logic [SP_W-1:0]        run_sp,
	output logic [SS_W-1:0]        run_ss,
	output logic [SCREEN_W-1:0]    run_screen,
	output logic                   scheduling_active
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam int OFF_W  = $clog2(NUM_SLOTS * STACK_BYTES + 1);

	function automatic logic [SLOT_W-1:0] rr_next(input logic [NUM_SLOTS-1:0] v,
		input logic [SLOT_W-1:0] c);
		logic [SLOT_W-1:0] r;
		int idx;
		r = c;
		for (int k = NUM_SLOTS; k >= 1; k--) begin
			idx = int'(c) + k;
			if (idx >= NUM_SLOTS)
				idx = idx - NUM_SLOTS;
			if (v[SLOT_W'(idx)])
				r = SLOT_W'(idx);
		end
		return r;
	endfunction

	logic                 enable_q;
	logic [BASE_W-1:0]    base_q;
	logic [MODE_W-1:0]    mode_q;
	logic [SP_W-1:0]      sp_q;
	logic [SS_W-1:0]      ss_q;
	logic [SCREEN_W-1:0]  scr_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic [SLOT_W-1:0]    cur_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ID_W-1:0]      idc_q;
	logic [SP_W-1:0]      dflt_sp_q;
	logic [SS_W-1:0]      dflt_ss_q;
	logic [STATUS_W-1:0]  status_q;
	logic [ID_W-1:0]      nid_q;
	logic [SP_W-1:0]      rd_sp_q;
	logic [SS_W-1:0]      rd_ss_q;
	logic [SCREEN_W-1:0]  rd_scr_q;

	logic [SP_W-1:0]      slot_sp  [NUM_SLOTS];
	logic [SS_W-1:0]      slot_ss  [NUM_SLOTS];
	logic [SCREEN_W-1:0]  slot_scr [NUM_SLOTS];

	logic                 active;
	logic                 free_found;
	logic [SLOT_W-1:0]    free_idx;
	logic [OFF_W-1:0]     sp_off;
	logic [SP_W-1:0]      init_sp;
	logic [NUM_SLOTS-1:0] valid_rm;

	logic [NUM_SLOTS-1:0] valid_d;
	logic [SLOT_W-1:0]    cur_d;
	logic [CNT_W-1:0]     cnt_d;
	logic [ID_W-1:0]      idc_d;
	logic                 dflt_we;
	logic [STATUS_W-1:0]  status_d;
	logic [ID_W-1:0]      nid_d;
	logic                 wr_ctx;
	logic                 wr_scr;
	logic [SLOT_W-1:0]    wr_idx;
	logic [SP_W-1:0]      wr_sp;
	logic [SS_W-1:0]      wr_ss;

	assign active = enable_q && (cnt_q != '0);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign sp_off  = OFF_W'({1'b0, free_idx} + 1'b1) * OFF_W'(STACK_BYTES);
	assign init_sp = {{(SP_W - BASE_W){1'b0}}, base_q} + SP_W'(sp_off)
		- SP_W'(ENTRY_FRAME_BYTES);

	always_comb begin
		valid_rm        = valid_q;
		valid_rm[cur_q] = 1'b0;
	end

	always_comb begin
		valid_d  = valid_q;
		cur_d    = cur_q;
		cnt_d    = cnt_q;
		idc_d    = idc_q;
		dflt_we  = 1'b0;
		status_d = STATUS_OK;
		nid_d    = '0;
		wr_ctx   = 1'b0;
		wr_scr   = 1'b0;
		wr_idx   = cur_q;
		wr_sp    = sp_q;
		wr_ss    = ss_q;
		case (mode_q)
			MODE_SWITCH: begin
				if (!active) begin
					dflt_we = 1'b1;
					idc_d   = idc_q + 1'b1;
				end else begin
					wr_ctx = 1'b1;
					cur_d  = rr_next(valid_q, cur_q);
				end
			end
			MODE_ADD: begin
				if ((cnt_q < CNT_W'(NUM_SLOTS)) && free_found) begin
					wr_ctx            = 1'b1;
					wr_scr            = 1'b1;
					wr_idx            = free_idx;
					wr_sp             = init_sp;
					wr_ss             = '0;
					valid_d[free_idx] = 1'b1;
					cnt_d             = cnt_q + 1'b1;
					nid_d             = idc_q;
					idc_d             = idc_q + 1'b1;
				end else begin
					status_d = STATUS_FULL;
				end
			end
			MODE_REMOVE: begin
				if ((cnt_q == '0) || !valid_q[cur_q]) begin
					status_d = STATUS_NO_TASK;
				end else begin
					valid_d = valid_rm;
					cnt_d   = cnt_q - 1'b1;
					if (enable_q && (cnt_q != CNT_W'(1)))
						cur_d = rr_next(valid_rm, cur_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MULTITASK_ENABLE:  enable_q <= cfg_wdata[0];
				REG_STACK_REGION_BASE: base_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			cur_q     <= '0;
			cnt_q     <= '0;
			idc_q     <= '0;
			dflt_sp_q <= '0;
			dflt_ss_q <= '0;
		end else if (cmd.exec) begin
			valid_q <= valid_d;
			cur_q   <= cur_d;
			cnt_q   <= cnt_d;
			idc_q   <= idc_d;
			if (dflt_we) begin
				dflt_sp_q <= sp_q;
				dflt_ss_q <= ss_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			sp_q   <= saved_sp;
			ss_q   <= saved_ss;
			scr_q  <= screen;
		end
		if (cmd.exec) begin
			status_q <= status_d;
			nid_q    <= nid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_ctx) begin
			slot_sp[wr_idx] <= wr_sp;
			slot_ss[wr_idx] <= wr_ss;
		end
		if (cmd.exec && wr_scr)
			slot_scr[wr_idx] <= scr_q;
		if (cmd.rd) begin
			rd_sp_q  <= slot_sp[cur_q];
			rd_ss_q  <= slot_ss[cur_q];
			rd_scr_q <= slot_scr[cur_q];
		end
	end

	assign status            = status_q;
	assign new_id            = nid_q;
	assign scheduling_active = active;
	assign run_sp            = active ? rd_sp_q : dflt_sp_q;
	assign run_ss            = active ? rd_ss_q : dflt_ss_q;
	assign run_screen        = rd_scr_q;

endmodule

// ===== rtl/round_robin_task_table_top.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_table_top
// Task slot table with round robin switching, task add and task remove.
// A started word passes through the update, slot read and report states;
// done strobes in the report state. The sequencer takes no new word until it
// is back in idle after the capture, update, slot read and report steps.
// Reset clears valid bits, scheduler state and configuration; slot contents
// stay undefined until written. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module round_robin_task_table_top
	import rrtt_pkg::*;
#(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int STACK_BYTES = STACK_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   start,
	output logic                   busy,
	input  logic [MODE_W-1:0]      mode,
	input  logic [SP_W-1:0]        saved_sp,
	input  logic [SS_W-1:0]        saved_ss,
	input  logic [SCREEN_W-1:0]    screen,
	output logic                   done,
	output logic [STATUS_W-1:0]    status,
	output logic [ID_W-1:0]        new_id,
	output logic [SP_W-1:0]        run_sp,
	output logic [SS_W-1:0]        run_ss,
	output logic [SCREEN_W-1:0]    run_screen,
	output logic                   scheduling_active
);

	rrtt_cmd_t cmd;

	rrtt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	rrtt_dp #(
		.NUM_SLOTS   (NUM_SLOTS),
		.STACK_BYTES (STACK_BYTES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.mode              (mode),
		.saved_sp          (saved_sp),
		.saved_ss          (saved_ss),
		.screen            (screen),
		.status            (status),
		.new_id            (new_id),
		.run_sp            (run_sp),
		.run_ss            (run_ss),
		.run_screen        (run_screen),
		.scheduling_active (scheduling_active)
	);

endmodule

// ===== test/task_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_table_checker
// Watches the register port, the command port and the result port of the
// round robin task table. Keeps its own copy of the slot table and the
// scheduler state, predicts the result word of each accepted command, and
// compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module task_table_checker
	import rrtt_pkg::*;
#(
	parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
	parameter int STACK_BYTES = STACK_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   start,
	input  logic                   busy,
	input  logic [MODE_W-1:0]      mode,
	input  logic [SP_W-1:0]        saved_sp,
	input  logic [SS_W-1:0]        saved_ss,
	input  logic [SCREEN_W-1:0]    screen,
	input  logic                   done,
	input  logic [STATUS_W-1:0]    status,
	input  logic [ID_W-1:0]        new_id,
	input  logic [SP_W-1:0]        run_sp,
	input  logic [SS_W-1:0]        run_ss,
	input  logic [SCREEN_W-1:0]    run_screen,
	input  logic                   scheduling_active,
	output int                     fail_count,
	output int                     outstanding
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     new_id;
		logic [SP_W-1:0]     run_sp;
		logic [SS_W-1:0]     run_ss;
		logic [SCREEN_W-1:0] run_screen;
		logic                active;
	} dispatch_t;

	logic                multitask_en;
	logic [BASE_W-1:0]   region_base;
	logic                slot_live [NUM_SLOTS];
	logic [SP_W-1:0]     slot_sp_m [NUM_SLOTS];
	logic [SS_W-1:0]     slot_ss_m [NUM_SLOTS];
	logic [SCREEN_W-1:0] slot_scr_m [NUM_SLOTS];
	int                  cur_slot;
	int                  task_cnt;
	logic [ID_W-1:0]     id_ctr;
	logic [SP_W-1:0]     dflt_sp;
	logic [SS_W-1:0]     dflt_ss;
	dispatch_t           dispatch_q [$];
	dispatch_t           want;
	int                  err_cnt;

	function automatic bit sched_on();
		return multitask_en && task_cnt > 0;
	endfunction

	// first valid slot after the current one, the current one last
	function automatic void rotate_slot();
		int origin;
		int k;
		origin = cur_slot;
		for (k = NUM_SLOTS; k >= 1; k--) begin
			if (slot_live[(origin + k) % NUM_SLOTS])
				cur_slot = (origin + k) % NUM_SLOTS;
		end
	endfunction

	function automatic dispatch_t predict_dispatch(input logic [MODE_W-1:0] m,
			input logic [SP_W-1:0] sp, input logic [SS_W-1:0] ss,
			input logic [SCREEN_W-1:0] scr);
		dispatch_t res;
		int free_slot;
		int i;
		free_slot = NUM_SLOTS;
		res.status = STATUS_OK;
		res.new_id = '0;
		case (m)
			MODE_SWITCH: begin
				if (!sched_on()) begin
					dflt_sp = sp;
					dflt_ss = ss;
					id_ctr = id_ctr + 1'b1;
				end else begin
					slot_sp_m[cur_slot] = sp;
					slot_ss_m[cur_slot] = ss;
					rotate_slot();
				end
			end
			MODE_ADD: begin
				if (task_cnt < NUM_SLOTS) begin
					for (i = NUM_SLOTS - 1; i >= 0; i--) begin
						if (!slot_live[i])
							free_slot = i;
					end
				end
				if (free_slot >= NUM_SLOTS) begin
					res.status = STATUS_FULL;
				end else begin
					slot_sp_m[free_slot] = SP_W'(region_base) + SP_W'(free_slot) * SP_W'(STACK_BYTES)
						+ SP_W'(STACK_BYTES) - SP_W'(ENTRY_FRAME_BYTES);
					slot_ss_m[free_slot] = '0;
					slot_scr_m[free_slot] = scr;
					res.new_id = id_ctr;
					id_ctr = id_ctr + 1'b1;
					slot_live[free_slot] = 1'b1;
					task_cnt++;
				end
			end
			MODE_REMOVE: begin
				if (task_cnt == 0 || !slot_live[cur_slot]) begin
					res.status = STATUS_NO_TASK;
				end else begin
					slot_live[cur_slot] = 1'b0;
					task_cnt--;
					if (sched_on())
						rotate_slot();
				end
			end
			default: ;
		endcase
		res.run_sp = sched_on() ? slot_sp_m[cur_slot] : dflt_sp;
		res.run_ss = sched_on() ? slot_ss_m[cur_slot] : dflt_ss;
		res.run_screen = slot_scr_m[cur_slot];
		res.active = sched_on();
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multitask_en = 1'b0;
			region_base = '0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_live[s] = 1'b0;
				slot_sp_m[s] = '0;
				slot_ss_m[s] = '0;
				slot_scr_m[s] = '0;
			end
			cur_slot = 0;
			task_cnt = 0;
			id_ctr = '0;
			dflt_sp = '0;
			dflt_ss = '0;
			dispatch_q.delete();
			err_cnt = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MULTITASK_ENABLE)
					multitask_en = cfg_wdata[0];
				else if (cfg_index == REG_STACK_REGION_BASE)
					region_base = cfg_wdata[BASE_W-1:0];
			end
			if (done) begin
				if (dispatch_q.size() == 0) begin
					$error("result word with no command pending");
					err_cnt++;
				end else begin
					want = dispatch_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						err_cnt++;
					end
					if (new_id !== want.new_id) begin
						$error("new_id: expected %0d, got %0d", want.new_id, new_id);
						err_cnt++;
					end
					if (run_sp !== want.run_sp) begin
						$error("run_sp: expected %h, got %h", want.run_sp, run_sp);
						err_cnt++;
					end
					if (run_ss !== want.run_ss) begin
						$error("run_ss: expected %h, got %h", want.run_ss, run_ss);
						err_cnt++;
					end
					if (run_screen !== want.run_screen) begin
						$error("run_screen: expected %0d, got %0d", want.run_screen, run_screen);
						err_cnt++;
					end
					if (scheduling_active !== want.active) begin
						$error("scheduling_active: expected %0d, got %0d", want.active,
							scheduling_active);
						err_cnt++;
					end
				end
			end
			if (start && !busy)
				dispatch_q.push_back(predict_dispatch(mode, saved_sp, saved_ss, screen));
			fail_count <= err_cnt;
			outstanding <= dispatch_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the round robin task table with a directed command list and then
// with random switch, add, remove and unused commands over several register
// settings and sender gap rates. A checker beside the block predicts and
// compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import rrtt_pkg::*;

	localparam int NUM_SLOTS    = NUM_SLOTS_DEF;
	localparam int STACK_BYTES  = STACK_BYTES_DEF;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 212;
	localparam int RANDOM_ITEMS = PHASES * PHASE_ITEMS;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [MODE_W-1:0]      mode = '0;
	logic [SP_W-1:0]        saved_sp = '0;
	logic [SS_W-1:0]        saved_ss = '0;
	logic [SCREEN_W-1:0]    screen = '0;
	logic                   done;
	logic [STATUS_W-1:0]    status;
	logic [ID_W-1:0]        new_id;
	logic [SP_W-1:0]        run_sp;
	logic [SS_W-1:0]        run_ss;
	logic [SCREEN_W-1:0]    run_screen;
	logic                   scheduling_active;
	int                     fail_count;
	int                     outstanding;
	int                     gap_pct = 25;
	int                     cycle_cnt = 0;

	always #4 clk = ~clk;

	round_robin_task_table_top #(
		.NUM_SLOTS   (NUM_SLOTS),
		.STACK_BYTES (STACK_BYTES)
	) i_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata, .start, .busy,
		.mode, .saved_sp, .saved_ss, .screen, .done, .status, .new_id,
		.run_sp, .run_ss, .run_screen, .scheduling_active
	);

	task_table_checker #(
		.NUM_SLOTS   (NUM_SLOTS),
		.STACK_BYTES (STACK_BYTES)
	) i_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata, .start, .busy,
		.mode, .saved_sp, .saved_ss, .screen, .done, .status, .new_id,
		.run_sp, .run_ss, .run_screen, .scheduling_active,
		.fail_count, .outstanding
	);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_setup(input logic en, input logic [BASE_W-1:0] base);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'({$urandom, $urandom});
		data[0] = en;
		cfg_we <= 1'b1;
		cfg_index <= REG_MULTITASK_ENABLE;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_index <= REG_STACK_REGION_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold the word until the block takes it
	task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [SP_W-1:0] sp,
			input logic [SS_W-1:0] ss, input logic [SCREEN_W-1:0] scr);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		saved_sp <= sp;
		saved_ss <= ss;
		screen <= scr;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int ph;
		int n;
		int idx;
		int pick;
		logic [MODE_W-1:0] m;
		logic [SP_W-1:0] sp;
		logic [SS_W-1:0] ss;
		logic [BASE_W-1:0] base;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_setup(1'b1, '0);

		// slot 0 is written first so no unwritten slot is ever reported
		send_cmd(MODE_ADD, '1, '1, 8'h00);
		send_cmd(MODE_ADD, '0, '0, 8'hFF);
		send_cmd(MODE_ADD, 64'h0123_4567_89AB_CDEF, 16'h5AA5, 8'hA5);
		send_cmd(MODE_ADD, '0, '0, 8'h5A);
		send_cmd(MODE_ADD, '0, '0, 8'h3C);
		send_cmd(MODE_SWITCH, '1, '1, 8'h00);
		send_cmd(MODE_SWITCH, '0, '0, 8'hFF);
		send_cmd(MODE_SWITCH, 64'hFEDC_BA98_7654_3210, 16'hA55A, 8'h00);
		send_cmd(MODE_UNUSED, '1, '1, '1);
		repeat (4) send_cmd(MODE_REMOVE, '0, '0, 8'h00);
		send_cmd(MODE_REMOVE, '1, '1, '1);
		send_cmd(MODE_SWITCH, '1, '1, 8'h00);
		send_cmd(MODE_ADD, '0, '0, 8'h81);
		drain();
		write_setup(1'b0, '1);
		send_cmd(MODE_ADD, '0, '0, 8'h7E);
		send_cmd(MODE_SWITCH, 64'h8000_0000_0000_0001, 16'h8001, 8'h00);
		send_cmd(MODE_REMOVE, '0, '0, 8'h00);
		send_cmd(MODE_REMOVE, '0, '0, 8'h00);
		send_cmd(MODE_UNUSED, '0, '0, 8'h00);

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph % 4)
				0: base = '0;
				1: base = '1;
				default: base = BASE_W'({$urandom, $urandom});
			endcase
			write_setup((ph % 3) != 1, base);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				idx = ph * PHASE_ITEMS + n;
				gap_pct = (idx < RANDOM_ITEMS / 3) ? 25 : (idx < 2 * RANDOM_ITEMS / 3) ? 86 : 0;
				pick = $urandom_range(99);
				m = (pick < 40) ? MODE_SWITCH : (pick < 65) ? MODE_ADD :
					(pick < 90) ? MODE_REMOVE : MODE_UNUSED;
				case ($urandom_range(9))
					0: sp = '0;
					1: sp = '1;
					default: sp = {$urandom, $urandom};
				endcase
				case ($urandom_range(9))
					0: ss = '0;
					1: ss = '1;
					default: ss = SS_W'($urandom);
				endcase
				send_cmd(m, sp, ss, SCREEN_W'($urandom));
			end
		end
		drain();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
